// File: sv/sed_pkg.sv
package sed_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_W      = 13;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int GRAD_W     = 12;
    localparam int SUM_W      = 21;
    localparam int SAT_LIMIT  = 65280;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;
        logic                       last;
    } sed_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sed_qstat_t;

endpackage

// File: sv/sed_front.sv
module sed_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [sed_pkg::CH_W-1:0]      in_red,
    input  logic [sed_pkg::CH_W-1:0]      in_green,
    input  logic [sed_pkg::CH_W-1:0]      in_blue,
    input  logic [sed_pkg::WIDTH_W-1:0]   width_eff,
    input  logic [sed_pkg::HEIGHT_W-1:0]  height_eff,
    input  sed_pkg::sed_qstat_t           qstat,
    output logic                          push,
    output sed_pkg::sed_entry_t           push_data
);

    typedef enum logic {
        F_IDLE,
        F_UPD
    } fstate_t;

    fstate_t                               state_reg;
    logic [2*sed_pkg::PIX_W-1:0]           line_mem [sed_pkg::MAX_WIDTH];
    logic [2*sed_pkg::PIX_W-1:0]           rdata_reg;
    logic [sed_pkg::PIX_W-1:0]             pix_reg;
    logic [2:0][2:0][sed_pkg::PIX_W-1:0]   win_reg;
    logic [2:0][2:0][sed_pkg::PIX_W-1:0]   win_next;
    logic [sed_pkg::COL_W-1:0]             in_col_reg;
    logic [sed_pkg::COL_W-1:0]             in_col_next;
    logic [sed_pkg::ROW_W-1:0]             in_row_reg;
    logic [sed_pkg::ROW_W-1:0]             in_row_next;
    logic [sed_pkg::COL_W-1:0]             out_col_reg;
    logic [sed_pkg::COL_W-1:0]             out_col_next;
    logic [sed_pkg::ROW_W-1:0]             out_row_reg;
    logic [sed_pkg::ROW_W-1:0]             out_row_next;
    logic                                  accept;
    logic                                  emit;
    logic                                  last;
    logic [2:0]                            row_ok;
    logic [2:0]                            col_ok;
    logic [sed_pkg::WIDTH_W-1:0]           in_col_inc;
    logic [sed_pkg::WIDTH_W-1:0]           out_col_inc;
    logic [sed_pkg::ROW_W:0]               out_row_inc;

    assign in_ready = (state_reg == F_IDLE) && !qstat.full;
    assign accept   = in_valid && in_ready;

    assign in_col_inc  = {1'b0, in_col_reg} + 1'b1;
    assign out_col_inc = {1'b0, out_col_reg} + 1'b1;
    assign out_row_inc = {1'b0, out_row_reg} + 1'b1;

    always_comb
    begin
        for (int y = 0; y < 3; y++)
        begin
            win_next[y][0] = win_reg[y][1];
            win_next[y][1] = win_reg[y][2];
        end
        win_next[0][2] = rdata_reg[2*sed_pkg::PIX_W-1:sed_pkg::PIX_W];
        win_next[1][2] = rdata_reg[sed_pkg::PIX_W-1:0];
        win_next[2][2] = pix_reg;

        emit = (in_row_reg >= sed_pkg::ROW_W'(2))
            || (in_row_reg == sed_pkg::ROW_W'(1) && in_col_reg != '0);
        last = ({1'b0, out_row_reg} >= {1'b0, height_eff})
            || (out_row_inc >= {1'b0, height_eff} && out_col_inc >= width_eff);
        row_ok[0] = out_row_reg != '0;
        row_ok[1] = 1'b1;
        row_ok[2] = out_row_inc < {1'b0, height_eff};
        col_ok[0] = out_col_reg != '0;
        col_ok[1] = 1'b1;
        col_ok[2] = out_col_inc < width_eff;

        for (int y = 0; y < 3; y++)
        begin
            for (int x = 0; x < 3; x++)
            begin
                push_data.win[y][x] = (row_ok[y] && col_ok[x]) ? win_next[y][x] : '0;
            end
        end
        push_data.last = last;
        push = (state_reg == F_UPD) && emit;

        if (in_col_inc >= width_eff)
        begin
            in_col_next = '0;
            in_row_next = (in_row_reg != '1) ? in_row_reg + 1'b1 : in_row_reg;
        end
        else
        begin
            in_col_next = in_col_inc[sed_pkg::COL_W-1:0];
            in_row_next = in_row_reg;
        end

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit)
        begin
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (out_col_inc >= width_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_inc[sed_pkg::ROW_W-1:0];
            end
            else
            begin
                out_col_next = out_col_inc[sed_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= line_mem[in_col_reg];
            pix_reg   <= func ? '0 : {in_red, in_green, in_blue};
        end
        if (state_reg == F_UPD)
        begin
            line_mem[in_col_reg] <= {rdata_reg[sed_pkg::PIX_W-1:0], pix_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            win_reg     <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_UPD;
                    end
                end
                F_UPD:
                begin
                    win_reg     <= win_next;
                    in_col_reg  <= in_col_next;
                    in_row_reg  <= in_row_next;
                    out_col_reg <= out_col_next;
                    out_row_reg <= out_row_next;
                    state_reg   <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/sed_queue.sv
module sed_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sed_pkg::sed_entry_t  push_data,
    input  logic                 pop,
    output sed_pkg::sed_entry_t  pop_data,
    output sed_pkg::sed_qstat_t  qstat
);

    sed_pkg::sed_entry_t slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic                do_push;
    logic                do_pop;

    assign qstat.full  = count_reg == 2'd2;
    assign qstat.empty = count_reg == 2'd0;
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/sed_back.sv
module sed_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sed_pkg::sed_qstat_t       qstat,
    input  sed_pkg::sed_entry_t       pop_data,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sed_pkg::CH_W-1:0]  edge_red,
    output logic [sed_pkg::CH_W-1:0]  edge_green,
    output logic [sed_pkg::CH_W-1:0]  edge_blue,
    output logic                      frame_last
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_ROOT,
        B_RND,
        B_DONE
    } bstate_t;

    bstate_t                                state_reg;
    logic signed [sed_pkg::GRAD_W-1:0]      gx_reg [3];
    logic signed [sed_pkg::GRAD_W-1:0]      gy_reg [3];
    logic signed [sed_pkg::GRAD_W-1:0]      gx_next [3];
    logic signed [sed_pkg::GRAD_W-1:0]      gy_next [3];
    logic [sed_pkg::SUM_W-1:0]              s_reg [3];
    logic [sed_pkg::SUM_W-1:0]              s_next [3];
    logic [sed_pkg::CH_W-1:0]               q_reg [3];
    logic [sed_pkg::CH_W-1:0]               q_root [3];
    logic [sed_pkg::CH_W-1:0]               q_rnd [3];
    logic [2:0]                             bit_reg;
    logic                                   last_reg;
    logic                                   load_out;

    assign pop      = (state_reg == B_IDLE) && !qstat.empty;
    assign load_out = (state_reg == B_DONE) && (!out_valid || out_ready);

    always_comb
    begin
        logic signed [sed_pkg::GRAD_W-1:0] pv [3][3];
        logic signed [2*sed_pkg::GRAD_W-1:0] sx;
        logic signed [2*sed_pkg::GRAD_W-1:0] sy;
        logic signed [2*sed_pkg::GRAD_W-1:0] ss;
        logic [sed_pkg::CH_W-1:0] t;
        logic [2*sed_pkg::CH_W-1:0] tt;
        logic [2*sed_pkg::CH_W-1:0] qsq;
        logic [2*sed_pkg::CH_W:0] qq;
        for (int c = 0; c < 3; c++)
        begin
            for (int y = 0; y < 3; y++)
            begin
                for (int x = 0; x < 3; x++)
                begin
                    pv[y][x] = $signed({4'b0,
                        pop_data.win[y][x][sed_pkg::PIX_W-1-sed_pkg::CH_W*c -: sed_pkg::CH_W]});
                end
            end
            gx_next[c] = pv[0][2] - pv[0][0] + (pv[1][2] <<< 1) - (pv[1][0] <<< 1)
                + pv[2][2] - pv[2][0];
            gy_next[c] = pv[2][0] - pv[0][0] + (pv[2][1] <<< 1) - (pv[0][1] <<< 1)
                + pv[2][2] - pv[0][2];

            sx = gx_reg[c] * gx_reg[c];
            sy = gy_reg[c] * gy_reg[c];
            ss = sx + sy;
            s_next[c] = ss[sed_pkg::SUM_W-1:0];

            t = q_reg[c] | (sed_pkg::CH_W'(1) << bit_reg);
            tt = t * t;
            q_root[c] = ({{(sed_pkg::SUM_W-2*sed_pkg::CH_W){1'b0}}, tt} <= s_reg[c])
                ? t : q_reg[c];

            qsq = q_reg[c] * q_reg[c];
            qq = {1'b0, qsq} + {{(sed_pkg::CH_W+1){1'b0}}, q_reg[c]};
            if (s_reg[c] > sed_pkg::SUM_W'(sed_pkg::SAT_LIMIT))
            begin
                q_rnd[c] = '1;
            end
            else if (s_reg[c] > {{(sed_pkg::SUM_W-2*sed_pkg::CH_W-1){1'b0}}, qq})
            begin
                q_rnd[c] = q_reg[c] + 1'b1;
            end
            else
            begin
                q_rnd[c] = q_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    gx_reg[c] <= gx_next[c];
                    gy_reg[c] <= gy_next[c];
                end
                B_SQ:
                begin
                    s_reg[c] <= s_next[c];
                    q_reg[c] <= '0;
                end
                B_ROOT:
                begin
                    q_reg[c] <= q_root[c];
                end
                B_RND:
                begin
                    q_reg[c] <= q_rnd[c];
                end
                B_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (pop)
        begin
            last_reg <= pop_data.last;
        end
        if (load_out)
        begin
            edge_red   <= q_reg[0];
            edge_green <= q_reg[1];
            edge_blue  <= q_reg[2];
            frame_last <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            bit_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    bit_reg   <= '1;
                    state_reg <= B_ROOT;
                end
                B_ROOT:
                begin
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0)
                    begin
                        state_reg <= B_RND;
                    end
                end
                B_RND:
                begin
                    state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/sobel_edge_rgb_unit.sv
// Channel   Handshake                Payload
// input     in_valid / in_ready      func, in_red, in_green, in_blue
// output    out_valid / out_ready    edge_red, edge_green, edge_blue, frame_last
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The front takes an input beat only while idle with queue room, then writes the line
// buffer back to the same column before it takes the next. The back works each result
// through gradient, squares, eight square-root steps, rounding and output load, and pops
// a new entry only after that load. A two-entry queue sits between them.
// Reset is asynchronous and active low; the line buffer is not cleared.
module sobel_edge_rgb_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [sed_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [sed_pkg::CH_W-1:0]      in_red,
    input  logic [sed_pkg::CH_W-1:0]      in_green,
    input  logic [sed_pkg::CH_W-1:0]      in_blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sed_pkg::CH_W-1:0]      edge_red,
    output logic [sed_pkg::CH_W-1:0]      edge_green,
    output logic [sed_pkg::CH_W-1:0]      edge_blue,
    output logic                          frame_last
);

    logic [sed_pkg::WIDTH_W-1:0]   frame_width_reg;
    logic [sed_pkg::HEIGHT_W-1:0]  frame_height_reg;
    logic [sed_pkg::WIDTH_W-1:0]   width_eff;
    logic [sed_pkg::HEIGHT_W-1:0]  height_eff;
    sed_pkg::sed_qstat_t           qstat;
    sed_pkg::sed_entry_t           push_data;
    sed_pkg::sed_entry_t           pop_data;
    logic                          push;
    logic                          pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sed_pkg::WIDTH_W'(640);
            frame_height_reg <= sed_pkg::HEIGHT_W'(480);
        end
        else if (cfg_valid)
        begin
            unique case (sed_pkg::cfg_index_t'(cfg_index))
                sed_pkg::CFG_WIDTH:
                begin
                    frame_width_reg <= cfg_data[sed_pkg::WIDTH_W-1:0];
                end
                sed_pkg::CFG_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[sed_pkg::HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            width_eff = sed_pkg::WIDTH_W'(1);
        end
        else if (frame_width_reg > sed_pkg::WIDTH_W'(sed_pkg::MAX_WIDTH))
        begin
            width_eff = sed_pkg::WIDTH_W'(sed_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = frame_width_reg;
        end
        if (frame_height_reg == '0)
        begin
            height_eff = sed_pkg::HEIGHT_W'(1);
        end
        else if (frame_height_reg > sed_pkg::HEIGHT_W'(sed_pkg::MAX_HEIGHT))
        begin
            height_eff = sed_pkg::HEIGHT_W'(sed_pkg::MAX_HEIGHT);
        end
        else
        begin
            height_eff = frame_height_reg;
        end
    end

    sed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .qstat      (qstat),
        .push       (push),
        .push_data  (push_data)
    );

    sed_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    sed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_red   (edge_red),
        .edge_green (edge_green),
        .edge_blue  (edge_blue),
        .frame_last (frame_last)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("Queue push while full.");

    a_qstat_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("Queue reports full and empty at once.");

    a_front_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Front took a beat during its write-back cycle.");
`endif

endmodule

// File: sim/sobel_edge_rgb_unit_tb.sv
module sobel_edge_rgb_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_pix_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [sed_pkg::CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic out_valid;
    logic out_ready;
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic frame_last;

    sobel_edge_rgb_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .edge_red(edge_red), .edge_green(edge_green), .edge_blue(edge_blue),
        .frame_last(frame_last)
    );

    logic [10:0] cur_width;
    logic [12:0] cur_height;
    logic [23:0] line_buf [0:2*sed_pkg::MAX_WIDTH-1];
    logic [23:0] win [0:2][0:2];
    int unsigned in_col, in_row, out_col, out_row;
    edge_pix_t edge_queue [$];
    int fail_count;
    bit rand_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned eff_w();
        if (cur_width < 1) return 1;
        if (cur_width > sed_pkg::MAX_WIDTH) return sed_pkg::MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int unsigned eff_h();
        if (cur_height < 1) return 1;
        if (cur_height > sed_pkg::MAX_HEIGHT) return sed_pkg::MAX_HEIGHT;
        return cur_height;
    endfunction

    function automatic logic [7:0] round_root(int unsigned s);
        int unsigned q;
        int unsigned t;
        q = 0;
        if (s > sed_pkg::SAT_LIMIT) return 8'd255;
        for (int b = 128; b != 0; b >>= 1)
        begin
            t = q + b;
            if (t * t <= s) q = t;
        end
        if (s > q * q + q) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    task automatic predict_edge(input logic f, input logic [23:0] rgb);
        int unsigned w, h, c, sh;
        logic [23:0] pix, top, mid;
        bit emit, last;
        bit rok [0:2];
        bit cok [0:2];
        int gx, gy, v;
        logic [7:0] mag [0:2];
        edge_pix_t e;
        w = eff_w();
        h = eff_h();
        c = in_col % sed_pkg::MAX_WIDTH;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        pix = f ? 24'd0 : rgb;
        top = line_buf[c];
        mid = line_buf[sed_pkg::MAX_WIDTH + c];
        line_buf[c] = mid;
        line_buf[sed_pkg::MAX_WIDTH + c] = pix;
        for (int y = 0; y < 3; y++)
        begin
            win[y][0] = win[y][1];
            win[y][1] = win[y][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            if (in_row < 13'h1FFF) in_row++;
        end
        else
            in_col++;
        if (!emit) return;
        last = (out_row >= h) || (out_row + 1 >= h && out_col + 1 >= w);
        rok[0] = out_row >= 1; rok[1] = 1; rok[2] = out_row + 1 < h;
        cok[0] = out_col >= 1; cok[1] = 1; cok[2] = out_col + 1 < w;
        for (int ch = 0; ch < 3; ch++)
        begin
            sh = 16 - 8 * ch;
            gx = 0;
            gy = 0;
            for (int y = 0; y < 3; y++)
                for (int x = 0; x < 3; x++)
                    if (rok[y] && cok[x])
                    begin
                        v = (win[y][x] >> sh) & 8'hFF;
                        gx += v * (x - 1) * ((y == 1) ? 2 : 1);
                        gy += v * (y - 1) * ((x == 1) ? 2 : 1);
                    end
            mag[ch] = round_root(gx * gx + gy * gy);
        end
        e.red = mag[0];
        e.green = mag[1];
        e.blue = mag[2];
        e.last = last;
        edge_queue.push_back(e);
        if (last)
        begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
    endtask

    task automatic send_pixel(input logic f, input logic [23:0] rgb);
        int unsigned idle;
        idle = rand_stall ? $urandom_range(0, 7) : 0;
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        func <= f;
        in_red <= rgb[23:16];
        in_green <= rgb[15:8];
        in_blue <= rgb[7:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_edge(f, rgb);
        @(negedge clk);
    endtask

    task automatic write_reg(input sed_pkg::cfg_index_t idx,
                             input logic [sed_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == sed_pkg::CFG_WIDTH) cur_width = val[10:0];
        else cur_height = val[12:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (edge_queue.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h);
        drain_results();
        write_reg(sed_pkg::CFG_WIDTH, sed_pkg::CFG_W'(w));
        write_reg(sed_pkg::CFG_HEIGHT, sed_pkg::CFG_W'(h));
    endtask

    task automatic send_frame(input int n, input bit noise);
        logic [23:0] rgb;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: rgb = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                default: rgb = 24'($urandom);
            endcase
            send_pixel(noise && ($urandom_range(0, 15) == 0), rgb);
        end
        for (int i = 0; i <= eff_w(); i++)
            send_pixel(1'b1, 24'($urandom));
    endtask

    task automatic test_directed();
        set_geometry(3, 3);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFF00FF);
        send_pixel(1'b1, 24'hFFFFFF);
        send_pixel(1'b0, 24'h00FF00);
        send_pixel(1'b0, 24'h123456);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFFFFFF);
        for (int i = 0; i < 4; i++) send_pixel(i[0], 24'hAAAAAA);
        set_geometry(1, 1);
        send_pixel(1'b0, 24'h808080);
        send_pixel(1'b1, 24'h0);
        send_pixel(1'b1, 24'h0);
        set_geometry(0, 0);
        send_pixel(1'b0, 24'h555555);
        send_pixel(1'b1, 24'h0);
        send_pixel(1'b1, 24'h0);
    endtask

    task automatic test_small_frames();
        int w, h;
        for (int k = 0; k < 11; k++)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            set_geometry(w, h);
            send_frame(w * h, k > 7);
            if (k == 4) drain_results();
        end
    endtask

    task automatic test_wide_frame();
        set_geometry(100, 1);
        send_frame(100, 1'b0);
        set_geometry(11'h7FF, 13'h1FFF);
        for (int i = 0; i < 20; i++)
            send_pixel(1'b0, 24'($urandom));
        set_geometry(2, 8191);
        send_frame(4, 1'b0);
        set_geometry(2, 2);
        send_frame(4, 1'b0);
    endtask

    always @(posedge clk)
    begin
        edge_pix_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (edge_queue.size() == 0)
            begin
                $error("unexpected result beat");
                fail_count++;
            end
            else
            begin
                e = edge_queue.pop_front();
                if (edge_red !== e.red)
                begin
                    $error("edge_red exp %0d got %0d", e.red, edge_red);
                    fail_count++;
                end
                if (edge_green !== e.green)
                begin
                    $error("edge_green exp %0d got %0d", e.green, edge_green);
                    fail_count++;
                end
                if (edge_blue !== e.blue)
                begin
                    $error("edge_blue exp %0d got %0d", e.blue, edge_blue);
                    fail_count++;
                end
                if (frame_last !== e.last)
                begin
                    $error("frame_last exp %0d got %0d", e.last, frame_last);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rand_stall) out_ready <= ($urandom_range(0, 7) < 5);
        else out_ready <= 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sed_pkg::CFG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        func = 1'b0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        out_ready = 1'b0;
        fail_count = 0;
        rand_stall = 1'b0;
        cur_width = 11'd640;
        cur_height = 13'd480;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        for (int i = 0; i < 2 * sed_pkg::MAX_WIDTH; i++) line_buf[i] = '0;
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++) win[y][x] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        rand_stall = 1'b1;
        test_small_frames();
        test_wide_frame();
        rand_stall = 1'b0;
        test_small_frames();
        drain_results();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/sed_pkg.sv
sv/sed_front.sv
sv/sed_queue.sv
sv/sed_back.sv
sv/sobel_edge_rgb_unit.sv
sim/sobel_edge_rgb_unit_tb.sv
